[sv/pblend_pkg.sv]
package pblend_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned PIX_W  = 32;
    localparam int unsigned OP_W   = 2;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // op codes on the request channel
    localparam logic [OP_W-1:0] OP_FILL    = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

    // register indexes on the configuration port, byte address is 4 * index
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_FILL_COLOR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TINT_RED   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TINT_GREEN = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TINT_BLUE  = 2'd3;

    // how the final stage forms the result pixel
    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_FILL_COPY = 2'd1,
        KIND_BLEND     = 2'd2,
        KIND_CONVERT   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [PIX_W-1:0]  fill_color;
        logic [CHAN_W-1:0] tint_red;
        logic [CHAN_W-1:0] tint_green;
        logic [CHAN_W-1:0] tint_blue;
    } cfg_t;

    // after the multiply stage
    typedef struct packed {
        kind_t             kind;
        logic [PIX_W-1:0]  raw;
        logic [CHAN_W-1:0] col_r;
        logic [CHAN_W-1:0] col_g;
        logic [CHAN_W-1:0] col_b;
        logic [CHAN_W-1:0] dk_r;
        logic [CHAN_W-1:0] dk_g;
        logic [CHAN_W-1:0] dk_b;
    } s1_t;

    // after the saturating add stage
    typedef struct packed {
        kind_t               kind;
        logic [PIX_W-1:0]    raw;
        logic [3*CHAN_W-1:0] blend;
    } s2_t;

endpackage

[sv/argb_pixel_blend_unit.sv]
// ARGB8888 pixel blend unit. Each request carries an op (fill, texture,
// convert to RGB565), a source texel and the current destination pixel, and
// yields one result: a write flag and the pixel to store. Fill blends the
// premultiplied fill_color over the destination (alpha 0 skips the write,
// alpha 255 copies the color with its alpha byte); texture blends the
// premultiplied source, optionally modulated by the tint registers, and a
// zero source alpha skips the write. Blended channels saturate at 255 and the
// blended alpha byte is 0. A skipped pixel returns out_pixel 0. The datapath
// is three register stages (multiply, saturating add, result select): a
// request passes through the multiply, add and result registers in turn; one
// request is taken every cycle unless a stall holds the pipe. out_stall holds
// the result register; a stage behind it keeps advancing while the stage ahead
// has room, and in_stall rises only when every stage holds a waiting request.
// Write the registers through the APB port only while no request is in flight.
module argb_pixel_blend_unit
    import pblend_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OP_W-1:0]  op,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             write_enable,
    output logic [PIX_W-1:0] out_pixel
);

    cfg_t             cfg;
    logic             s1_ready;
    logic             s1_valid;
    s1_t              s1_data;
    logic             s2_ready;
    logic             s2_valid;
    s2_t              s2_data;
    logic             out_ready;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             we_reg;
    logic             we_next;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;

    pblend_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: pick coverage and color, tint and destination products
    pblend_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .op        (op),
        .src_pixel (src_pixel),
        .dst_pixel (dst_pixel),
        .dn_ready  (s2_ready),
        .up_ready  (s1_ready),
        .valid     (s1_valid),
        .data      (s1_data)
    );

    assign in_stall = !s1_ready;

    // Stage 2: saturating per-channel add
    pblend_add_stage u_add (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .in_data  (s1_data),
        .dn_ready (out_ready),
        .up_ready (s2_ready),
        .valid    (s2_valid),
        .data     (s2_data)
    );

    // Stage 3: select the result form and hold it until taken
    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (s2_data.kind)
            KIND_FILL_COPY:
            begin
                we_next  = 1'b1;
                pix_next = s2_data.raw;
            end
            KIND_BLEND:
            begin
                we_next  = 1'b1;
                pix_next = {8'd0, s2_data.blend};
            end
            KIND_CONVERT:
            begin
                we_next  = 1'b1;
                pix_next = s2_data.raw;
            end
            default:
            begin
                // skipped pixel: drop the write, zero the payload
                we_next  = 1'b0;
                pix_next = '0;
            end
        endcase
    end

    assign out_valid_next = out_ready ? s2_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            we_reg  <= we_next;
            pix_reg <= pix_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign out_pixel    = pix_reg;

endmodule

[sv/pblend_regs.sv]
module pblend_regs
    import pblend_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FILL_COLOR: cfg_next.fill_color = pwdata;
                REG_TINT_RED:   cfg_next.tint_red   = pwdata[CHAN_W-1:0];
                REG_TINT_GREEN: cfg_next.tint_green = pwdata[CHAN_W-1:0];
                REG_TINT_BLUE:  cfg_next.tint_blue  = pwdata[CHAN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FILL_COLOR: prdata = cfg_reg.fill_color;
            REG_TINT_RED:   prdata = {24'd0, cfg_reg.tint_red};
            REG_TINT_GREEN: prdata = {24'd0, cfg_reg.tint_green};
            REG_TINT_BLUE:  prdata = {24'd0, cfg_reg.tint_blue};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_color <= 32'hFFFF_FFFF;
            cfg_reg.tint_red   <= CHAN_MAX;
            cfg_reg.tint_green <= CHAN_MAX;
            cfg_reg.tint_blue  <= CHAN_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/pblend_mul_stage.sv]
module pblend_mul_stage
    import pblend_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [OP_W-1:0]  op,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    input  logic             dn_ready,
    output logic             up_ready,
    output logic             valid,
    output s1_t              data
);

    logic              valid_reg;
    logic              valid_next;
    s1_t               data_reg;
    s1_t               data_next;
    logic              plain;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] k;
    logic [15:0]       tp_r;
    logic [15:0]       tp_g;
    logic [15:0]       tp_b;
    logic [15:0]       dp_r;
    logic [15:0]       dp_g;
    logic [15:0]       dp_b;

    assign up_ready = !valid_reg || dn_ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    assign plain = (cfg.tint_red == CHAN_MAX) && (cfg.tint_green == CHAN_MAX)
                && (cfg.tint_blue == CHAN_MAX);

    // tint products on the source channels
    assign tp_r = 16'(src_pixel[23:16]) * 16'(cfg.tint_red);
    assign tp_g = 16'(src_pixel[15:8])  * 16'(cfg.tint_green);
    assign tp_b = 16'(src_pixel[7:0])   * 16'(cfg.tint_blue);

    // coverage comes from the fill color or the source texel
    assign alpha = (op == OP_FILL) ? cfg.fill_color[31:24] : src_pixel[31:24];
    assign k     = CHAN_MAX - alpha;

    assign dp_r = 16'(dst_pixel[23:16]) * 16'(k);
    assign dp_g = 16'(dst_pixel[15:8])  * 16'(k);
    assign dp_b = 16'(dst_pixel[7:0])   * 16'(k);

    always_comb
    begin
        data_next.kind  = KIND_NONE;
        data_next.raw   = '0;
        data_next.col_r = src_pixel[23:16];
        data_next.col_g = src_pixel[15:8];
        data_next.col_b = src_pixel[7:0];
        data_next.dk_r  = dp_r[15:8];
        data_next.dk_g  = dp_g[15:8];
        data_next.dk_b  = dp_b[15:8];
        case (op)
            OP_FILL:
            begin
                data_next.col_r = cfg.fill_color[23:16];
                data_next.col_g = cfg.fill_color[15:8];
                data_next.col_b = cfg.fill_color[7:0];
                data_next.raw   = cfg.fill_color;
                if (alpha == CHAN_MAX)
                    data_next.kind = KIND_FILL_COPY;
                else if (alpha != '0)
                    data_next.kind = KIND_BLEND;
            end
            OP_TEXTURE:
            begin
                // full coverage gives k = 0, so the blend path also covers the copy
                if (alpha != '0)
                    data_next.kind = KIND_BLEND;
                if (!plain)
                begin
                    data_next.col_r = tp_r[15:8];
                    data_next.col_g = tp_g[15:8];
                    data_next.col_b = tp_b[15:8];
                end
            end
            OP_CONVERT:
            begin
                data_next.kind = KIND_CONVERT;
                data_next.raw  = {16'd0, src_pixel[23:19], src_pixel[15:10], src_pixel[7:3]};
            end
            default:
            begin
                data_next.kind = KIND_NONE;
            end
        endcase
    end

    assign valid_next = up_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

endmodule

[sv/pblend_add_stage.sv]
module pblend_add_stage
    import pblend_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  s1_t  in_data,
    input  logic dn_ready,
    output logic up_ready,
    output logic valid,
    output s2_t  data
);

    logic            valid_reg;
    logic            valid_next;
    s2_t             data_reg;
    s2_t             data_next;
    logic [CHAN_W:0] sum_r;
    logic [CHAN_W:0] sum_g;
    logic [CHAN_W:0] sum_b;

    assign up_ready = !valid_reg || dn_ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    assign sum_r = {1'b0, in_data.dk_r} + {1'b0, in_data.col_r};
    assign sum_g = {1'b0, in_data.dk_g} + {1'b0, in_data.col_g};
    assign sum_b = {1'b0, in_data.dk_b} + {1'b0, in_data.col_b};

    // clamp each channel instead of carrying into its neighbor
    always_comb
    begin
        data_next.kind  = in_data.kind;
        data_next.raw   = in_data.raw;
        data_next.blend = {sum_r[CHAN_W] ? CHAN_MAX : sum_r[CHAN_W-1:0],
                           sum_g[CHAN_W] ? CHAN_MAX : sum_g[CHAN_W-1:0],
                           sum_b[CHAN_W] ? CHAN_MAX : sum_b[CHAN_W-1:0]};
    end

    assign valid_next = up_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

endmodule

[sim/tb_argb_pixel_blend_unit.sv]
`timescale 1ns / 100ps

module tb_argb_pixel_blend_unit;
    import pblend_pkg::*;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned NUM_PHASES     = 10;
    localparam int unsigned RAND_PER_PHASE = 120;
    // three register stages; leave a little margin after the last result
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned HOLD_AFTER     = 400;
    localparam int unsigned TIMEOUT_NS     = 5_000_000;

    // op code that the block must answer with a skipped write
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  req_op;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
    } pixel_request_t;

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] pix;
    } pixel_result_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [3:0]       paddr        = '0;
    logic [31:0]      pwdata       = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  op           = '0;
    logic [PIX_W-1:0] src_pixel    = '0;
    logic [PIX_W-1:0] dst_pixel    = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic             write_enable;
    logic [PIX_W-1:0] out_pixel;

    // requests waiting to be offered, and blend results waiting to come back
    pixel_request_t pixel_requests[$];
    pixel_result_t  expected_pixels[$];

    // copy of the register file as the block should hold it
    cfg_t        shadow_cfg;
    int unsigned requests_queued   = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatch_count    = 0;
    // steady: no gaps and no random stalls during this phase
    bit          steady            = 1'b0;
    // hold_off: long receiver stall driven from its own process
    logic        hold_off          = 1'b0;

    argb_pixel_blend_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .src_pixel    (src_pixel),
        .dst_pixel    (dst_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .out_pixel    (out_pixel)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // One color channel of the blend: scale the destination by the
    // inverse coverage, add the premultiplied color, clamp at 255.
    function automatic logic [7:0] mix_chan(input logic [7:0] d, input logic [7:0] k,
                                            input logic [7:0] c);
        logic [15:0] prod;
        logic [8:0]  sum;
        prod = 16'(d) * 16'(k);
        sum  = {1'b0, prod[15:8]} + {1'b0, c};
        return sum[8] ? CHAN_MAX : sum[7:0];
    endfunction

    // Blend premultiplied r, g, b with coverage a over dst; alpha byte is 0.
    function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] dst,
                                                    input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b, input logic [7:0] a);
        logic [7:0] k;
        k = CHAN_MAX - a;
        return {8'h00, mix_chan(dst[23:16], k, r), mix_chan(dst[15:8], k, g),
                mix_chan(dst[7:0], k, b)};
    endfunction

    // Work out the write flag and pixel for one request under shadow_cfg.
    function automatic pixel_result_t predict_pixel(input pixel_request_t req);
        pixel_result_t res;
        logic [7:0]    a;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic [15:0]   prod;
        res = '0;
        case (req.req_op)
            OP_FILL:
            begin
                a = shadow_cfg.fill_color[31:24];
                if (a == CHAN_MAX)
                begin
                    // opaque fill: copy the color, alpha byte included
                    res.we  = 1'b1;
                    res.pix = shadow_cfg.fill_color;
                end
                else if (a != 8'h00)
                begin
                    res.we  = 1'b1;
                    res.pix = blend_over(req.dst, shadow_cfg.fill_color[23:16],
                                         shadow_cfg.fill_color[15:8],
                                         shadow_cfg.fill_color[7:0], a);
                end
            end
            OP_TEXTURE:
            begin
                a = req.src[31:24];
                if (a != 8'h00)
                begin
                    r = req.src[23:16];
                    g = req.src[15:8];
                    b = req.src[7:0];
                    // any tint below full strength switches on the modulation
                    if (!(shadow_cfg.tint_red == CHAN_MAX && shadow_cfg.tint_green == CHAN_MAX
                          && shadow_cfg.tint_blue == CHAN_MAX))
                    begin
                        prod = 16'(r) * 16'(shadow_cfg.tint_red);
                        r    = prod[15:8];
                        prod = 16'(g) * 16'(shadow_cfg.tint_green);
                        g    = prod[15:8];
                        prod = 16'(b) * 16'(shadow_cfg.tint_blue);
                        b    = prod[15:8];
                    end
                    res.we  = 1'b1;
                    res.pix = (a == CHAN_MAX) ? {8'h00, r, g, b}
                                              : blend_over(req.dst, r, g, b, a);
                end
            end
            OP_CONVERT:
            begin
                res.we  = 1'b1;
                res.pix = {16'h0000, req.src[23:19], req.src[15:10], req.src[7:3]};
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------

    // Gap length: mostly none, often short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // ARGB texel with alpha biased toward the special values 0, 1, 254 and 255.
    function automatic logic [PIX_W-1:0] rand_texel();
        int unsigned ra;
        int unsigned rc;
        logic [7:0]  a;
        logic [23:0] rgb;
        ra = $urandom_range(99);
        rc = $urandom_range(99);
        if (ra < 12)       a = 8'h00;
        else if (ra < 30)  a = 8'hFF;
        else if (ra < 35)  a = 8'h01;
        else if (ra < 40)  a = 8'hFE;
        else               a = 8'($urandom());
        if (rc < 8)        rgb = 24'hFFFFFF;
        else if (rc < 12)  rgb = 24'h000000;
        else               rgb = 24'($urandom());
        return {a, rgb};
    endfunction

    function automatic logic [PIX_W-1:0] rand_dst();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 32'hFFFFFFFF;
        if (r < 14)
            return 32'h00000000;
        return $urandom();
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return OP_FILL;
        if (r < 75)
            return OP_TEXTURE;
        if (r < 95)
            return OP_CONVERT;
        return OP_UNUSED;
    endfunction

    // Tint factor: full strength often enough that plain blends stay common.
    function automatic logic [7:0] rand_tint();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return CHAN_MAX;
        if (r < 45)
            return 8'h00;
        return 8'($urandom());
    endfunction

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------

    task automatic queue_request(input logic [OP_W-1:0] req_op, input logic [PIX_W-1:0] src,
                                 input logic [PIX_W-1:0] dst);
        pixel_requests.push_back('{req_op: req_op, src: src, dst: dst});
        requests_queued++;
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input cfg_t c);
        apb_write({REG_FILL_COLOR, 2'b00}, c.fill_color);
        apb_write({REG_TINT_RED, 2'b00}, {24'h0, c.tint_red});
        apb_write({REG_TINT_GREEN, 2'b00}, {24'h0, c.tint_green});
        apb_write({REG_TINT_BLUE, 2'b00}, {24'h0, c.tint_blue});
        shadow_cfg = c;
    endtask

    // Wait until every queued request has come back, then let the pipe settle.
    task automatic wait_idle();
        while (results_checked != requests_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Request driver: offer queued requests with random gaps. Hold the
    // payload while the block stalls; predict on acceptance.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        pixel_request_t       req;
        int unsigned          gap_left;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_pixels.push_back(predict_pixel('{req_op: op, src: src_pixel,
                                                          dst: dst_pixel}));
                requests_accepted++;
            end
            // Advance only when the slot is free; a stalled request stays put.
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_requests.size() > 0)
                begin
                    req       = pixel_requests.pop_front();
                    in_valid  <= 1'b1;
                    op        <= req.req_op;
                    src_pixel <= req.src;
                    dst_pixel <= req.dst;
                    gap_left  = idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // prediction, then pick the stall for the next cycle.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        pixel_result_t        want;
        int unsigned          stall_left;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result: write_enable %0d, out_pixel %08h",
                           write_enable, out_pixel);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (write_enable !== want.we)
                    begin
                        $error("write_enable: expected %0d, actual %0d", want.we, write_enable);
                        mismatch_count++;
                    end
                    if (out_pixel !== want.pix)
                    begin
                        $error("out_pixel: expected %08h, actual %08h", want.pix, out_pixel);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left == 0)
                stall_left = idle_len();
            if (stall_left != 0)
                stall_left--;
            // one assignment per cycle: random stall or the long hold-off
            out_stall <= hold_off || (stall_left != 0);
        end
    end

    // ---------------------------------------------------------------
    // Back-pressure: once traffic is under way and plenty is still queued,
    // hold the receiver for a long stretch so the pipe fills and in_stall
    // rises while the driver keeps offering requests.
    // ---------------------------------------------------------------
    initial
    begin : hold_receiver
        wait (requests_accepted >= HOLD_AFTER && pixel_requests.size() > 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Drop the run if it hangs.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence: reset, then a series of register settings. Each
    // phase waits for the pipe to empty, reprograms the registers (phase 0
    // keeps reset values), runs its directed requests if any, then a random batch.
    // ---------------------------------------------------------------
    initial
    begin : run_phases
        cfg_t phase_cfg;
        shadow_cfg = '{fill_color: 32'hFFFFFFFF, tint_red: CHAN_MAX,
                       tint_green: CHAN_MAX, tint_blue: CHAN_MAX};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: phase_cfg = shadow_cfg;   // reset values, opaque white fill
                1: phase_cfg = '{32'h00000000, 8'h00, 8'h00, 8'h00};
                2: phase_cfg = '{32'h80FF4020, CHAN_MAX, CHAN_MAX, CHAN_MAX};
                3: phase_cfg = '{32'h01FFFFFF, CHAN_MAX, CHAN_MAX, 8'hFE};
                4: phase_cfg = '{32'hFE808080, 8'h80, 8'h40, 8'hC8};
                default: phase_cfg = '{rand_texel(), rand_tint(), rand_tint(), rand_tint()};
            endcase
            if (ph != 0)
                program_regs(phase_cfg);
            steady = (ph == 3 || ph == 7);

            case (ph)
                0:
                begin
                    // opaque fill copy, texture alpha edges, saturation, convert, unused op
                    queue_request(OP_FILL, 32'h00000000, 32'h00000000);
                    queue_request(OP_TEXTURE, 32'h00FFFFFF, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'hFF123456, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'h80FFFFFF, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'h01000000, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'hFE000000, 32'hFFFFFFFF);
                    queue_request(OP_CONVERT, 32'hFFFFFFFF, 32'h00000000);
                    queue_request(OP_CONVERT, 32'h00000000, 32'hFFFFFFFF);
                    queue_request(OP_CONVERT, 32'h12345678, 32'hFFFFFFFF);
                    queue_request(OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF);
                end
                1:
                begin
                    // transparent fill skips; zero tints black out the texel
                    queue_request(OP_FILL, 32'hFFFFFFFF, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'hFFFFFFFF, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'h80FFFFFF, 32'h80808080);
                end
                2:
                begin
                    queue_request(OP_FILL, 32'h00000000, 32'hFFFFFFFF);
                    queue_request(OP_FILL, 32'hFFFFFFFF, 32'h00000000);
                    queue_request(OP_TEXTURE, 32'h7F7F7F7F, 32'hFFFFFFFF);
                end
                3:
                begin
                    // one tint just below full strength still modulates
                    queue_request(OP_FILL, 32'h00000000, 32'hFFFFFFFF);
                    queue_request(OP_FILL, 32'h00000000, 32'h00000000);
                    queue_request(OP_TEXTURE, 32'hFFFFFFFF, 32'h00000000);
                    queue_request(OP_TEXTURE, 32'h40FFFFFF, 32'hFFFFFFFF);
                end
                4:
                begin
                    queue_request(OP_FILL, 32'h00000000, 32'hFFFFFFFF);
                    queue_request(OP_TEXTURE, 32'hFFFFFFFF, 32'h00000000);
                    queue_request(OP_TEXTURE, 32'hC0A0B0C0, 32'h55AA55AA);
                end
                default: ;
            endcase

            repeat (RAND_PER_PHASE) queue_request(rand_op(), rand_texel(), rand_dst());
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
